[rtl/windowed_nearest_point_select_defines.svh]
// Assertion macros shared by the windowed nearest-point select RTL.
`ifndef WINDOWED_NEAREST_POINT_SELECT_DEFINES_SVH
`define WINDOWED_NEAREST_POINT_SELECT_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define WNPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define WNPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wnps_pkg.sv]
// Shared constants and types for the windowed nearest-point select.
package wnps_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DIM_W          = 15;
  localparam int KEY_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 8;
  localparam int BUSY_W         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INCL_SECOND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_RADIUS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y      = 3'd6;

  typedef struct packed {
    logic last;
    logic vis;
  } wnps_flags_t;

endpackage

[rtl/wnps_front.sv]
// Front pipeline: window test and squared distance to the query point.
module wnps_front #(
  parameter int COORD_BITS = wnps_pkg::COORD_BITS_DEF,
  localparam int DIST_W = 2 * COORD_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [COORD_BITS-1:0]         in_x,
  input  logic [COORD_BITS-1:0]         in_y,
  input  logic                          in_sec,
  input  logic [wnps_pkg::KEY_W-1:0]    in_key,
  input  logic                          in_last,
  input  logic [wnps_pkg::DIM_W-1:0]    view_width,
  input  logic [wnps_pkg::DIM_W-1:0]    view_height,
  input  logic [wnps_pkg::DIM_W-1:0]    edge_margin,
  input  logic                          include_secondary,
  input  logic [COORD_BITS-1:0]         query_x,
  input  logic [COORD_BITS-1:0]         query_y,
  output logic                          o_valid,
  output wnps_pkg::wnps_flags_t         o_flags,
  output logic [wnps_pkg::KEY_W-1:0]    o_key,
  output logic [COORD_BITS-1:0]         o_x,
  output logic [COORD_BITS-1:0]         o_y,
  output logic [DIST_W-1:0]             o_dist,
  output logic [wnps_pkg::BUSY_W-1:0]   o_busy
);

  localparam int CMP_W  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;

  logic signed [CMP_W-1:0] px_e, py_e, lo_e, hix_e, hiy_e;
  logic                    vis0;
  logic [DIFF_W-1:0]       dx0, dy0;

  logic                        v1_r, v2_r, v3_r, v4_r;
  wnps_pkg::wnps_flags_t       f1_r, f2_r, f3_r, f4_r;
  logic [wnps_pkg::KEY_W-1:0]  k1_r, k2_r, k3_r, k4_r;
  logic [COORD_BITS-1:0]       x1_r, x2_r, x3_r, x4_r;
  logic [COORD_BITS-1:0]       y1_r, y2_r, y3_r, y4_r;
  logic [DIFF_W-1:0]           dx1_r, dy1_r;
  logic [DIFF_W-1:0]           ax1, ay1;
  logic [MAG_W-1:0]            mx1, my1;
  logic [MAG_W-1:0]            mx2_r, my2_r;
  logic [SQ_W-1:0]             sqx3_r, sqy3_r;
  logic [DIST_W-1:0]           dist4_r;

  // Window bounds, margin included on every side.
  always_comb begin
    px_e  = {{(CMP_W-COORD_BITS){in_x[COORD_BITS-1]}}, in_x};
    py_e  = {{(CMP_W-COORD_BITS){in_y[COORD_BITS-1]}}, in_y};
    lo_e  = -$signed(CMP_W'(edge_margin));
    hix_e = $signed(CMP_W'(view_width) + CMP_W'(edge_margin));
    hiy_e = $signed(CMP_W'(view_height) + CMP_W'(edge_margin));
    vis0  = (include_secondary || !in_sec) &&
            (px_e >= lo_e) && (px_e <= hix_e) && (py_e >= lo_e) && (py_e <= hiy_e);
    dx0   = {in_x[COORD_BITS-1], in_x} - {query_x[COORD_BITS-1], query_x};
    dy0   = {in_y[COORD_BITS-1], in_y} - {query_y[COORD_BITS-1], query_y};
  end

  always_comb begin
    ax1 = dx1_r[DIFF_W-1] ? (~dx1_r + DIFF_W'(1)) : dx1_r;
    ay1 = dy1_r[DIFF_W-1] ? (~dy1_r + DIFF_W'(1)) : dy1_r;
  end

  // Saturate each difference at 2^31 when the coordinate is wide enough to need it.
  generate
    if (COORD_BITS >= 32) begin : g_cap
      assign mx1 = (ax1 > DIFF_W'(64'h8000_0000)) ? MAG_W'(64'h8000_0000) : MAG_W'(ax1);
      assign my1 = (ay1 > DIFF_W'(64'h8000_0000)) ? MAG_W'(64'h8000_0000) : MAG_W'(ay1);
    end else begin : g_nocap
      assign mx1 = MAG_W'(ax1);
      assign my1 = MAG_W'(ay1);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    f1_r    <= '{last: in_last, vis: vis0};
    k1_r    <= in_key;
    x1_r    <= in_x;
    y1_r    <= in_y;
    dx1_r   <= dx0;
    dy1_r   <= dy0;
    f2_r    <= f1_r;
    k2_r    <= k1_r;
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    mx2_r   <= mx1;
    my2_r   <= my1;
    f3_r    <= f2_r;
    k3_r    <= k2_r;
    x3_r    <= x2_r;
    y3_r    <= y2_r;
    sqx3_r  <= mx2_r * mx2_r;
    sqy3_r  <= my2_r * my2_r;
    f4_r    <= f3_r;
    k4_r    <= k3_r;
    x4_r    <= x3_r;
    y4_r    <= y3_r;
    dist4_r <= DIST_W'(sqx3_r) + DIST_W'(sqy3_r);
  end

  assign o_valid = v4_r;
  assign o_flags = f4_r;
  assign o_key   = k4_r;
  assign o_x     = x4_r;
  assign o_y     = y4_r;
  assign o_dist  = dist4_r;
  assign o_busy  = wnps_pkg::BUSY_W'(v1_r) + wnps_pkg::BUSY_W'(v2_r) +
                   wnps_pkg::BUSY_W'(v3_r) + wnps_pkg::BUSY_W'(v4_r);

endmodule

[rtl/wnps_queue.sv]
// Small register-file queue between the front pipeline and the select stage.
module wnps_queue #(
  parameter int W     = 8,
  parameter int DEPTH = wnps_pkg::QUEUE_DEPTH,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  wdata,
  input  logic          pop,
  output logic [W-1:0]  rdata,
  output logic          empty,
  output logic [CW-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[rtl/wnps_back.sv]
// Select stage: nearest-point tracking, scan report and output register.
module wnps_back #(
  parameter int COORD_BITS = wnps_pkg::COORD_BITS_DEF,
  localparam int DIST_W = 2 * COORD_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  wnps_pkg::wnps_flags_t       q_flags,
  input  logic [wnps_pkg::KEY_W-1:0]  q_key,
  input  logic [COORD_BITS-1:0]       q_x,
  input  logic [COORD_BITS-1:0]       q_y,
  input  logic [DIST_W-1:0]           q_dist,
  input  logic [wnps_pkg::DIM_W-1:0]  hit_radius,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_visible,
  output logic                        out_last,
  output logic                        out_found,
  output logic [wnps_pkg::KEY_W-1:0]  out_key,
  output logic [COORD_BITS-1:0]       out_x,
  output logic [COORD_BITS-1:0]       out_y
);

  localparam int RSQ_W = 2 * wnps_pkg::DIM_W;
  localparam int LIM_W = (DIST_W > RSQ_W) ? DIST_W : RSQ_W;

  logic [RSQ_W-1:0]            rad_sq_r;
  logic                        have_best_r;
  logic [DIST_W-1:0]           best_dist_r;
  logic [wnps_pkg::KEY_W-1:0]  best_key_r;
  logic [COORD_BITS-1:0]       best_x_r, best_y_r;
  logic                        out_valid_r;
  logic                        out_visible_r, out_last_r, out_found_r;
  logic [wnps_pkg::KEY_W-1:0]  out_key_r;
  logic [COORD_BITS-1:0]       out_x_r, out_y_r;

  logic [LIM_W-1:0]            limit, dq;
  logic                        take, have_nxt, report;
  logic [DIST_W-1:0]           dist_nxt;
  logic [wnps_pkg::KEY_W-1:0]  key_nxt;
  logic [COORD_BITS-1:0]       x_nxt, y_nxt;

  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  // Qualify against the held best, or against the radius when nothing is held.
  always_comb begin
    limit    = have_best_r ? LIM_W'(best_dist_r) : LIM_W'(rad_sq_r);
    dq       = LIM_W'(q_dist);
    take     = q_flags.vis && (dq <= limit) &&
               (!have_best_r || (dq < limit) || (q_key < best_key_r));
    have_nxt = have_best_r || take;
    dist_nxt = take ? q_dist : best_dist_r;
    key_nxt  = take ? q_key  : best_key_r;
    x_nxt    = take ? q_x    : best_x_r;
    y_nxt    = take ? q_y    : best_y_r;
    report   = q_flags.last && have_nxt;
  end

  always_ff @(posedge clk) begin
    rad_sq_r <= hit_radius * hit_radius;
    if (!rst_n) begin
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        // Clear the search at the end of each scan.
        have_best_r <= have_nxt && !q_flags.last;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      best_dist_r   <= dist_nxt;
      best_key_r    <= key_nxt;
      best_x_r      <= x_nxt;
      best_y_r      <= y_nxt;
      out_visible_r <= q_flags.vis;
      out_last_r    <= q_flags.last;
      out_found_r   <= report;
      out_key_r     <= report ? key_nxt : '0;
      out_x_r       <= report ? x_nxt : '0;
      out_y_r       <= report ? y_nxt : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;
  assign out_last    = out_last_r;
  assign out_found   = out_found_r;
  assign out_key     = out_key_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;

endmodule

[rtl/windowed_nearest_point_select.sv]
// Windowed nearest-point select: top level with configuration registers.
// Streams projected points (signed Q12.4) and answers one result beat per point.
// A point is visible when it survives the secondary-type filter and lies in the
// view rectangle widened by edge_margin, bounds included. Among visible points
// the block holds the one nearest (query_x, query_y) by squared distance, no
// farther than hit_radius; an equal distance goes to the smaller key. The beat
// marked tlast reports the winner in found/best fields and clears the search.
// Rate: one point per clock, sustained, with both sides streaming. An input beat
// passes four stages of the distance pipeline (difference, magnitude, squares,
// sum), then the eight-entry queue and the output register to its result beat.
// The queue grants credit against the four stages in flight, so in_tready falls
// only when the result side has been stalled long enough to fill it.
// Configuration writes are registered and are to be made only while no point is
// in flight; the block itself does not enforce this.
`include "windowed_nearest_point_select_defines.svh"

module windowed_nearest_point_select #(
  parameter int COORD_BITS = wnps_pkg::COORD_BITS_DEF,
  localparam int CFG_W  = (COORD_BITS > wnps_pkg::DIM_W) ? COORD_BITS : wnps_pkg::DIM_W,
  localparam int IN_W   = ((2 * COORD_BITS + wnps_pkg::KEY_W + 7) / 8) * 8,
  localparam int OUT_W  = ((2 * COORD_BITS + wnps_pkg::KEY_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input beat
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,  // point_x, point_y, point_key
  input  logic                              in_tuser,  // is_secondary
  input  logic                              in_tlast,  // last_point
  // Result beat
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata, // best_key, best_x, best_y
  output logic [1:0]                        out_tuser, // visible, found
  output logic                              out_tlast, // scan_done
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [wnps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data
);

  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam int FLG_W  = $bits(wnps_pkg::wnps_flags_t);
  localparam int Q_W    = FLG_W + wnps_pkg::KEY_W + 2 * COORD_BITS + DIST_W;
  localparam int DEPTH  = wnps_pkg::QUEUE_DEPTH;
  localparam int QCNT_W = $clog2(DEPTH + 1);
  localparam int CRED_W = QCNT_W + 1;

  // Configuration registers
  logic [wnps_pkg::DIM_W-1:0] view_width_r, view_height_r, edge_margin_r, hit_radius_r;
  logic                       incl_second_r;
  logic [COORD_BITS-1:0]      query_x_r, query_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_width_r  <= '0;
      view_height_r <= '0;
      edge_margin_r <= '0;
      incl_second_r <= 1'b1;
      hit_radius_r  <= '0;
      query_x_r     <= '0;
      query_y_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wnps_pkg::REG_VIEW_WIDTH:  view_width_r  <= cfg_data[wnps_pkg::DIM_W-1:0];
        wnps_pkg::REG_VIEW_HEIGHT: view_height_r <= cfg_data[wnps_pkg::DIM_W-1:0];
        wnps_pkg::REG_EDGE_MARGIN: edge_margin_r <= cfg_data[wnps_pkg::DIM_W-1:0];
        wnps_pkg::REG_INCL_SECOND: incl_second_r <= cfg_data[0];
        wnps_pkg::REG_HIT_RADIUS:  hit_radius_r  <= cfg_data[wnps_pkg::DIM_W-1:0];
        wnps_pkg::REG_QUERY_X:     query_x_r     <= cfg_data[COORD_BITS-1:0];
        wnps_pkg::REG_QUERY_Y:     query_y_r     <= cfg_data[COORD_BITS-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front: window test and distance pipeline
  logic                        in_fire;
  logic                        f_valid;
  wnps_pkg::wnps_flags_t       f_flags;
  logic [wnps_pkg::KEY_W-1:0]  f_key;
  logic [COORD_BITS-1:0]       f_x, f_y;
  logic [DIST_W-1:0]           f_dist;
  logic [wnps_pkg::BUSY_W-1:0] f_busy;

  // Queue
  logic [Q_W-1:0]              q_wdata, q_rdata;
  logic                        q_pop, q_empty;
  logic [QCNT_W-1:0]           q_count;
  wnps_pkg::wnps_flags_t       q_flags;
  logic [wnps_pkg::KEY_W-1:0]  q_key;
  logic [COORD_BITS-1:0]       q_x, q_y;
  logic [DIST_W-1:0]           q_dist;

  // Result fields
  logic                        r_visible, r_found;
  logic [wnps_pkg::KEY_W-1:0]  r_key;
  logic [COORD_BITS-1:0]       r_x, r_y;

  // Accept only while every point in flight still has a queue slot waiting.
  assign in_tready = (CRED_W'(q_count) + CRED_W'(f_busy)) < CRED_W'(DEPTH);
  assign in_fire   = in_tvalid && in_tready;

  wnps_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_fire           (in_fire),
    .in_x              (in_tdata[COORD_BITS-1:0]),
    .in_y              (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_sec            (in_tuser),
    .in_key            (in_tdata[2*COORD_BITS+wnps_pkg::KEY_W-1:2*COORD_BITS]),
    .in_last           (in_tlast),
    .view_width        (view_width_r),
    .view_height       (view_height_r),
    .edge_margin       (edge_margin_r),
    .include_secondary (incl_second_r),
    .query_x           (query_x_r),
    .query_y           (query_y_r),
    .o_valid           (f_valid),
    .o_flags           (f_flags),
    .o_key             (f_key),
    .o_x               (f_x),
    .o_y               (f_y),
    .o_dist            (f_dist),
    .o_busy            (f_busy)
  );

  assign q_wdata = {f_flags, f_key, f_y, f_x, f_dist};

  wnps_queue #(.W(Q_W), .DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  assign {q_flags, q_key, q_y, q_x, q_dist} = q_rdata;

  wnps_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_flags     (q_flags),
    .q_key       (q_key),
    .q_x         (q_x),
    .q_y         (q_y),
    .q_dist      (q_dist),
    .hit_radius  (hit_radius_r),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_visible (r_visible),
    .out_last    (out_tlast),
    .out_found   (r_found),
    .out_key     (r_key),
    .out_x       (r_x),
    .out_y       (r_y)
  );

  assign out_tdata = OUT_W'({r_y, r_x, r_key});
  assign out_tuser = {r_found, r_visible};

  // The credit window must keep the queue from ever overflowing.
  `WNPS_ASSERT_SAME(a_queue_no_overflow, f_valid && !q_pop, q_count < QCNT_W'(DEPTH), "queue overflow")
  // A hit is reported only on the beat that closes a scan.
  `WNPS_ASSERT_SAME(a_found_on_last, out_tvalid && out_tuser[1], out_tlast, "found without scan end")
  // Without a hit the best fields read as zero.
  `WNPS_ASSERT_SAME(a_empty_report_zero, out_tvalid && !out_tuser[1], out_tdata == '0, "stale best fields")
  // An accepted point is held somewhere in the front or the queue on the next cycle.
  `WNPS_ASSERT_NEXT(a_point_in_flight, in_fire, (CRED_W'(q_count) + CRED_W'(f_busy)) != '0, "point lost")

endmodule
